// ----- design/sli_pkg.sv -----
// Shared definitions for the sorted list insert/remove block.
// Holds operation and status codes, the cell control struct and defaults.
// No dependencies.
package sli_pkg;

    // Default number of entries the store can hold.
    localparam int DEFAULT_CAPACITY = 16;

    // Field widths fixed by the interface.
    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Operation codes; the fourth code is unused and ignored.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic                      ins;
        logic                      rem;
        logic signed [VALUE_W-1:0] val;
        logic [POS_W-1:0]          pos;
    } cell_ctrl_t;

endpackage

// ----- design/sli_cell.sv -----
// One cell of the sorted chain: holds a single entry and shifts with its neighbors.
// Depends on sli_pkg.
module sli_cell
    import sli_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                      aclk,
    input  cell_ctrl_t                ctrl,
    input  logic [CNT_W-1:0]          count,
    input  logic                      left_less,
    input  logic signed [VALUE_W-1:0] left_entry,
    input  logic signed [VALUE_W-1:0] right_entry,
    output logic                      less,
    output logic signed [VALUE_W-1:0] entry
);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic                      occupied;

    // The cell holds a live entry when its index is below the count.
    assign occupied = (32'(IDX) < 32'(count));

    // Live entries smaller than the new value stay put on an insert.
    assign less  = occupied && (entry_reg < ctrl.val);
    assign entry = entry_reg;

    // Insert: take the new value at the boundary, the left entry above it.
    // Remove: every cell at or above the position takes its right neighbor.
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins && !less) begin
            entry_next = left_less ? ctrl.val : left_entry;
        end else if (ctrl.rem && (IDX >= int'(ctrl.pos))) begin
            entry_next = right_entry;
        end
    end

    // Entry storage carries no reset; contents above the count are unused.
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ----- design/sorted_list_insert_remove.sv -----
// Sorted store of signed 32-bit values: top level with the cell chain and result register.
// Depends on sli_pkg and sli_cell.
//
// Usage:
//   Requests arrive on the s_ channel (s_op, s_value, s_position) with valid/ready.
//   Insert places s_value in ascending order, read returns the entry at
//   s_position, remove returns it and closes the gap. Every request yields
//   exactly one result on the m_ channel: m_result_value, m_status and
//   m_entry_count (count after the operation).
//   Each cell compares its entry with the new value and takes its own,
//   its left or its right neighbor's entry in the same cycle, so every
//   operation completes in the cycle it is accepted.
//   The result is registered: m_valid rises at the accepting edge. One request is
//   taken every cycle while the result register is empty or being drained;
//   s_ready is low only while a result waits and m_ready is low.
//   Reset empties the store (count zero) and clears m_valid; entry contents
//   are not cleared. While the receiver stalls the result holds and the
//   store does not change.
module sorted_list_insert_remove
    import sli_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [OP_W-1:0]           s_op,
    input  logic signed [VALUE_W-1:0] s_value,
    input  logic [POS_W-1:0]          s_position,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_result_value,
    output logic [STAT_W-1:0]         m_status,
    output logic [COUNT_W-1:0]        m_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int NREAD = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      m_valid_reg;
    logic signed [VALUE_W-1:0] m_result_value_reg;
    logic [STAT_W-1:0]         m_status_reg;
    logic [COUNT_W-1:0]        m_entry_count_reg;

    logic                      accept;
    logic                      full;
    logic                      badpos;
    logic                      ins_ok;
    logic                      rem_ok;
    logic                      rd_ok;
    logic signed [VALUE_W-1:0] rd_value;
    logic signed [VALUE_W-1:0] res_value;
    logic [STAT_W-1:0]         res_status;
    cell_ctrl_t                ctrl;

    logic                      less  [CAPACITY];
    logic signed [VALUE_W-1:0] entry [CAPACITY];

    // Handshake: the result register frees up when it is empty or drained.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Request decode.
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign badpos = (32'(s_position) >= 32'(count_reg));
    assign ins_ok = accept && (s_op == OP_INSERT) && !full;
    assign rem_ok = accept && (s_op == OP_REMOVE) && !badpos;
    assign rd_ok  = ((s_op == OP_READ) || (s_op == OP_REMOVE)) && !badpos;

    assign ctrl.ins = ins_ok;
    assign ctrl.rem = rem_ok;
    assign ctrl.val = s_value;
    assign ctrl.pos = s_position;

    // Chain of cells, each wired to its left and right neighbor.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                      l_less;
        logic signed [VALUE_W-1:0] l_entry;
        logic signed [VALUE_W-1:0] r_entry;

        if (i == 0) begin : g_first
            assign l_less  = 1'b1;
            assign l_entry = s_value;
        end else begin : g_mid
            assign l_less  = less[i-1];
            assign l_entry = entry[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign r_entry = entry[i];
        end else begin : g_inner
            assign r_entry = entry[i+1];
        end

        sli_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .left_less   (l_less),
            .left_entry  (l_entry),
            .right_entry (r_entry),
            .less        (less[i]),
            .entry       (entry[i])
        );
    end

    // Read select over the cells a position can address.
    always_comb begin
        rd_value = '0;
        for (int i = 0; i < NREAD; i++) begin
            if (s_position == POS_W'(i)) begin
                rd_value = entry[i];
            end
        end
    end

    // Result fields and next count.
    always_comb begin
        res_value  = '0;
        res_status = ST_OK;
        count_next = count_reg;
        case (s_op)
            OP_INSERT: begin
                if (full) begin
                    res_status = ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_READ: begin
                if (badpos) begin
                    res_status = ST_BADPOS;
                end else begin
                    res_value = rd_value;
                end
            end
            OP_REMOVE: begin
                if (badpos) begin
                    res_status = ST_BADPOS;
                end else begin
                    res_value  = rd_value;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    // Entry count and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload is loaded on every accepted transfer.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_result_value_reg <= rd_ok ? res_value : '0;
            m_status_reg       <= res_status;
            m_entry_count_reg  <= COUNT_W'(count_next);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_value_reg;
    assign m_status       = m_status_reg;
    assign m_entry_count  = m_entry_count_reg;

    // The count never runs past the capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

    // A successful insert grows the store by exactly one entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ins_ok |=> (count_reg == $past(count_reg) + CNT_W'(1)))
    else $error("insert did not grow the count by one");

    // Error results never carry a value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != ST_OK)) |-> (m_result_value_reg == '0))
    else $error("error result carries a nonzero value");

endmodule

// ----- tb/sv/tb_sorted_list_insert_remove.sv -----
// Self-checking testbench for the sorted list insert/remove block.
// Depends on sli_pkg and sorted_list_insert_remove; a scoreboard class predicts every result.
`timescale 1ns / 100ps

module tb_sorted_list_insert_remove
    import sli_pkg::*;
();

    localparam int DEPTH       = DEFAULT_CAPACITY;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 60;

    // The fourth operation code has no name in the package; the block ignores it.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // One predicted result of the store.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [STAT_W-1:0]         status;
        logic [COUNT_W-1:0]        count;
    } list_outcome_t;

    // Scoreboard: keeps a shadow copy of the sorted store and the results still owed.
    class sorted_store_checker;
        logic signed [VALUE_W-1:0] entries [DEPTH];
        int                        count;
        list_outcome_t             awaited [$];
        int                        errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        // Applies an accepted request to the shadow store and queues its result.
        function void note_request(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] value,
                                   logic [POS_W-1:0] position);
            list_outcome_t outcome;
            int            slot;
            outcome.value  = '0;
            outcome.status = ST_OK;
            if (op == OP_INSERT) begin
                if (count >= DEPTH) begin
                    outcome.status = ST_FULL;
                end else begin
                    // The new value goes after every smaller entry.
                    slot = 0;
                    while (slot < count && entries[slot] < value) slot++;
                    for (int i = count; i > slot; i--) entries[i] = entries[i-1];
                    entries[slot] = value;
                    count++;
                end
            end else if (op == OP_READ || op == OP_REMOVE) begin
                if (int'(position) >= count) begin
                    outcome.status = ST_BADPOS;
                end else begin
                    outcome.value = entries[position];
                    if (op == OP_REMOVE) begin
                        for (int i = position; i + 1 < count; i++) entries[i] = entries[i+1];
                        count--;
                    end
                end
            end
            outcome.count = COUNT_W'(count);
            awaited.push_back(outcome);
        endfunction

        // Compares one result transfer with the oldest prediction.
        function void check_result(logic signed [VALUE_W-1:0] value, logic [STAT_W-1:0] status,
                                   logic [COUNT_W-1:0] entry_count);
            list_outcome_t want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result: value %0d status %0d count %0d",
                         $time, value, status, entry_count);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (value !== want.value) begin
                $display("%0t: value mismatch: expected %0d actual %0d",
                         $time, want.value, value);
                errors++;
            end
            if (status !== want.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, status);
                errors++;
            end
            if (entry_count !== want.count) begin
                $display("%0t: entry count mismatch: expected %0d actual %0d",
                         $time, want.count, entry_count);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [OP_W-1:0]           s_op;
    logic signed [VALUE_W-1:0] s_value;
    logic [POS_W-1:0]          s_position;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [VALUE_W-1:0] m_result_value;
    logic [STAT_W-1:0]         m_status;
    logic [COUNT_W-1:0]        m_entry_count;

    sorted_store_checker store_model = new();

    int  snd_idle_pct;
    int  rcv_idle_pct;
    int  holds_asked;
    int  holds_served;
    int  cycle_count;
    bit  fill_mode;

    sorted_list_insert_remove uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_value        (s_value),
        .s_position     (s_position),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_status       (m_status),
        .m_entry_count  (m_entry_count)
    );

    // Clock with a 12 ns period.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: ends the run if it takes far longer than any correct run could.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d results outstanding", $time, store_model.pending());
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random stalls per cycle, plus a long hold-off whenever one is requested.
    initial begin
        m_ready      = 1'b0;
        holds_served = 0;
        forever begin
            @(negedge aclk);
            if (holds_served < holds_asked) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // Result monitor: every completed result transfer is checked.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            store_model.check_result(m_result_value, m_status, m_entry_count);
        end
    end

    // Offers one request and waits for its transfer; entered and left at a falling edge.
    task automatic send_request(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] value,
                                input logic [POS_W-1:0] position);
        int gap;
        if ($urandom_range(99) < snd_idle_pct) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_op       <= op;
        s_value    <= value;
        s_position <= position;
        do @(posedge aclk); while (!s_ready);
        store_model.note_request(op, value, position);
        @(negedge aclk);
    endtask

    // Picks a value: often full random, often from a narrow band so duplicates occur.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50) return $urandom;
        if (sel < 80) return VALUE_W'($signed($urandom_range(15)) - 8);
        case ($urandom_range(3))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh0000_0000;
            default: return -32'sd1;
        endcase
    endfunction

    // Random traffic that swings the store between empty and full.
    task automatic run_random(input int items);
        int                r;
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  position;
        for (int n = 0; n < items; n++) begin
            if (store_model.count >= DEPTH) fill_mode = 1'b0;
            if (store_model.count == 0) fill_mode = 1'b1;
            if ($urandom_range(99) < 3) fill_mode = !fill_mode;
            r = $urandom_range(99);
            if ($urandom_range(99) < 5) op = OP_UNUSED;
            else if (fill_mode) op = (r < 65) ? OP_INSERT : (r < 82) ? OP_READ : OP_REMOVE;
            else op = (r < 20) ? OP_INSERT : (r < 45) ? OP_READ : OP_REMOVE;
            // Mostly legal positions, sometimes anything the field allows.
            if (store_model.count > 0 && $urandom_range(99) < 85)
                position = POS_W'($urandom_range(store_model.count - 1));
            else
                position = POS_W'($urandom_range(15));
            send_request(op, pick_value(), position);
        end
    endtask

    // Main sequence: reset, directed cases, then three random phases.
    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_op         = OP_INSERT;
        s_value      = '0;
        s_position   = '0;
        holds_asked  = 0;
        fill_mode    = 1'b1;
        snd_idle_pct = 30;
        rcv_idle_pct = 68;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Bad positions on an empty store, and the unused operation code.
        send_request(OP_READ, 32'sd0, 4'd0);
        send_request(OP_REMOVE, -32'sd1, 4'd15);
        send_request(OP_UNUSED, 32'sh5A5A_A5A5, 4'd9);
        // Extremes and equal values.
        send_request(OP_INSERT, 32'sh7FFF_FFFF, 4'd0);
        send_request(OP_INSERT, 32'sh8000_0000, 4'd0);
        send_request(OP_INSERT, 32'sd0, 4'd0);
        send_request(OP_INSERT, -32'sd1, 4'd0);
        send_request(OP_INSERT, 32'sd5, 4'd0);
        send_request(OP_INSERT, 32'sd5, 4'd0);
        send_request(OP_READ, 32'sd0, 4'd0);
        send_request(OP_READ, 32'sd0, 4'd5);
        send_request(OP_READ, 32'sd0, 4'd6);
        send_request(OP_REMOVE, 32'sd0, 4'd3);
        // Fill the store, then insert into a full store and work at the last position.
        for (int i = 0; i < DEPTH - 5; i++) send_request(OP_INSERT, pick_value(), 4'd0);
        send_request(OP_INSERT, 32'sd123, 4'd0);
        send_request(OP_READ, 32'sd0, 4'd15);
        send_request(OP_REMOVE, 32'sd0, 4'd15);

        // Phase one, with a long receiver hold-off in the middle.
        run_random(60);
        holds_asked++;
        run_random(73);

        snd_idle_pct = 68;
        rcv_idle_pct = 30;
        run_random(133);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_random(133);

        s_valid <= 1'b0;
        while (store_model.pending() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (store_model.errors == 0 && store_model.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/sli_pkg.sv
design/sli_cell.sv
design/sorted_list_insert_remove.sv
tb/sv/tb_sorted_list_insert_remove.sv
